/* sv/gbba_pkg.sv */
package gbba_pkg;

    // Fixed geometry of the bitmap store.
    localparam int MAX_GROUPS  = 8;
    localparam int MAX_BPG     = 8192;
    localparam int WORD_BITS   = 64;
    localparam int GRP_W       = $clog2(MAX_GROUPS);
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int OFF_W       = $clog2(MAX_BPG);
    localparam int WPG_W       = OFF_W - BIT_W;
    localparam int ADDR_W      = GRP_W + WPG_W;
    localparam int MEM_DEPTH   = MAX_GROUPS * MAX_BPG / WORD_BITS;
    localparam int CNT_W       = OFF_W + 1;
    localparam int BLK_W       = 17;
    localparam int NG_W        = 4;
    localparam int BPG_W       = 14;

    // Operation codes.
    localparam logic [1:0] FN_ALLOC = 2'd0;
    localparam logic [1:0] FN_FREE  = 2'd1;
    localparam logic [1:0] FN_MARK  = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_SPACE = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_FREE     = 3'd3;
    localparam logic [2:0] ST_USED     = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FIRST_DATA_BLOCK = 2'd0;
    localparam logic [1:0] CFG_BLOCKS_PER_GROUP = 2'd1;
    localparam logic [1:0] CFG_GROUPS_IN_USE    = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_GRP,
        S_SCAN,
        S_CALC,
        S_LOCATE,
        S_LRD,
        S_LMOD,
        S_FINISH
    } t_state;

    // Result of the block-to-group mapping.
    typedef struct packed {
        logic             done;
        logic             in_range;
        logic [GRP_W-1:0] grp;
        logic [OFF_W-1:0] offset;
    } t_loc_res;

    // Position of the lowest set bit of a word.
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (w[k]) begin
                pos = BIT_W'(k);
            end
        end
        return pos;
    endfunction

endpackage

/* sv/gbba_locate.sv */
module gbba_locate
    import gbba_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [BLK_W-1:0] i_block,
    input  logic             i_fdb,
    input  logic [BPG_W-1:0] i_bpg,
    input  logic [NG_W-1:0]  i_ng,
    output t_loc_res         o_res
);

    logic             r_busy;
    logic [BLK_W-1:0] r_rem;
    logic [GRP_W-1:0] r_g;
    t_loc_res         r_res;
    logic [NG_W-1:0]  ng_last;
    logic             rem_fits;

    assign ng_last  = i_ng - NG_W'(1);
    assign rem_fits = r_rem < BLK_W'(i_bpg);
    assign o_res    = r_res;

    // Repeated subtraction of the group size, one group per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_res.done <= 1'b0;
        end else begin
            r_res.done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_block - BLK_W'(i_fdb);
                r_g    <= '0;
                r_busy <= (i_block >= BLK_W'(i_fdb));
                if (i_block < BLK_W'(i_fdb)) begin
                    r_res.done     <= 1'b1;
                    r_res.in_range <= 1'b0;
                end
            end else if (r_busy) begin
                if (rem_fits) begin
                    r_busy         <= 1'b0;
                    r_res.done     <= 1'b1;
                    r_res.in_range <= 1'b1;
                    r_res.grp      <= r_g;
                    r_res.offset   <= r_rem[OFF_W-1:0];
                end else if (r_g == ng_last[GRP_W-1:0]) begin
                    r_busy         <= 1'b0;
                    r_res.done     <= 1'b1;
                    r_res.in_range <= 1'b0;
                end else begin
                    r_rem <= r_rem - BLK_W'(i_bpg);
                    r_g   <= r_g + GRP_W'(1);
                end
            end
        end
    end

endmodule

/* sv/grouped_bitmap_block_allocator.sv */
// Block allocator over a used/free bitmap split into up to eight block groups.
// After reset the bitmap memory is cleared in a pass over all 1024 words during which
// no item is taken; configuration writes are taken at any time. Items are handled
// one at a time. A free or mark steps over the groups one by one (up to 7) to map
// the block number to its group, then reads and updates its bitmap word. An allocate
// checks the groups in turn and scans the 64-bit bitmap words of each group that is
// not full, one word per cycle from the single read port of the bitmap memory;
// a group of 8192 blocks holds 128 words. A finished result sits in an output
// register, so the next item is taken while it waits.
module grouped_bitmap_block_allocator
    import gbba_pkg::*;
#(
    parameter int TDATA_W = 24
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [BPG_W-1:0]   i_cfg_data,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // [16:0] block_in
    input  logic [1:0]         s_axis_tuser,   // [1:0] func
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [16:0] block_out
    output logic [2:0]         m_axis_tuser    // [2:0] status
);

    t_state r_state, n_state;

    // Configuration registers.
    logic             r_fdb;
    logic [BPG_W-1:0] r_bpg;
    logic [NG_W-1:0]  r_giu;
    logic [BPG_W-1:0] eff_bpg;
    logic [NG_W-1:0]  eff_ng;
    logic [BPG_W-1:0] bpg_m1;
    logic [WPG_W-1:0] last_w;

    // Bitmap memory.
    logic [WORD_BITS-1:0] mem [MEM_DEPTH];
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_wa;
    logic [ADDR_W-1:0]    mem_ra;
    logic [WORD_BITS-1:0] mem_wd;

    // Work registers.
    logic [ADDR_W-1:0]  r_clr_addr;
    logic [1:0]         r_func;
    logic [GRP_W:0]     r_grp;
    logic [WPG_W-1:0]   r_rd_w;
    logic               r_issue_done;
    logic               r_pend;
    logic [WPG_W-1:0]   r_chk_w;
    logic [OFF_W-1:0]   r_bit;
    logic [CNT_W-1:0]   r_cnt [MAX_GROUPS];
    logic [2:0]         r_status;
    logic [BLK_W-1:0]   r_res_block;
    logic               r_out_valid;
    logic [2:0]         r_out_status;
    logic [BLK_W-1:0]   r_out_block;

    logic               s_accept;
    logic               out_free;
    logic               loc_start;
    t_loc_res           loc_res;
    logic               grp_done;
    logic               grp_full;
    logic [BPG_W-1:0]   lim;
    logic [WORD_BITS-1:0] word_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic [BIT_W-1:0]   free_pos;
    logic               scan_hit;
    logic               scan_exhausted;
    logic               cur_bit;
    logic [BLK_W-1:0]   grp_base;

    // Effective geometry: group size rounded down to 8 and clamped, groups clamped.
    always_comb begin
        eff_bpg = {r_bpg[BPG_W-1:3], 3'b000};
        if (eff_bpg == '0) begin
            eff_bpg = BPG_W'(8);
        end else if (eff_bpg > BPG_W'(MAX_BPG)) begin
            eff_bpg = BPG_W'(MAX_BPG);
        end
        eff_ng = r_giu;
        if (eff_ng == '0) begin
            eff_ng = NG_W'(1);
        end else if (eff_ng > NG_W'(MAX_GROUPS)) begin
            eff_ng = NG_W'(MAX_GROUPS);
        end
    end

    assign bpg_m1 = eff_bpg - BPG_W'(1);
    assign last_w = bpg_m1[OFF_W-1:BIT_W];

    // Block number to group mapping for the free and mark paths.
    gbba_locate u_locate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (loc_start),
        .i_block (s_axis_tdata[BLK_W-1:0]),
        .i_fdb   (r_fdb),
        .i_bpg   (eff_bpg),
        .i_ng    (eff_ng),
        .o_res   (loc_res)
    );

    // Handshake and scan status.
    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign grp_done      = (r_grp >= (GRP_W+1)'(eff_ng));
    assign grp_full      = (r_cnt[r_grp[GRP_W-1:0]] >= CNT_W'(eff_bpg));

    // Free bits of the word under test, limited to the group size.
    assign lim       = eff_bpg - {1'b0, r_chk_w, {BIT_W{1'b0}}};
    assign word_mask = (lim >= BPG_W'(WORD_BITS)) ? {WORD_BITS{1'b1}}
                     : ((WORD_BITS'(1) << lim[BIT_W-1:0]) - WORD_BITS'(1));
    assign free_bits      = ~r_rd_data & word_mask;
    assign free_pos       = lowest_set(free_bits);
    assign scan_hit       = r_pend && (free_bits != '0);
    assign scan_exhausted = r_pend && (free_bits == '0) && (r_chk_w == last_w);
    assign cur_bit        = r_rd_data[r_bit[BIT_W-1:0]];
    assign grp_base       = BLK_W'(r_grp[GRP_W-1:0]) * BLK_W'(eff_bpg);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    priority case (s_axis_tuser)
                        FN_ALLOC:         n_state = S_GRP;
                        FN_FREE, FN_MARK: n_state = S_LOCATE;
                        default:          n_state = S_FINISH;
                    endcase
                end
            end
            S_GRP: begin
                if (grp_done) begin
                    n_state = S_FINISH;
                end else if (!grp_full) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_state = S_CALC;
                end else if (scan_exhausted) begin
                    n_state = S_GRP;
                end
            end
            S_CALC:   n_state = S_FINISH;
            S_LOCATE: begin
                if (loc_res.done) begin
                    n_state = loc_res.in_range ? S_LRD : S_FINISH;
                end
            end
            S_LRD:    n_state = S_LMOD;
            S_LMOD:   n_state = S_FINISH;
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_CLEAR;
        endcase
    end

    // Memory control and unit start.
    always_comb begin
        mem_we    = 1'b0;
        mem_wa    = '0;
        mem_wd    = '0;
        mem_ra    = '0;
        loc_start = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr_addr;
            end
            S_IDLE: begin
                loc_start = s_accept && (s_axis_tuser == FN_FREE || s_axis_tuser == FN_MARK);
            end
            S_SCAN: begin
                mem_ra = {r_grp[GRP_W-1:0], r_rd_w};
                if (scan_hit) begin
                    mem_we = 1'b1;
                    mem_wa = {r_grp[GRP_W-1:0], r_chk_w};
                    mem_wd = r_rd_data | (WORD_BITS'(1) << free_pos);
                end
            end
            S_LRD: begin
                mem_ra = {r_grp[GRP_W-1:0], r_bit[OFF_W-1:BIT_W]};
            end
            S_LMOD: begin
                mem_wa = {r_grp[GRP_W-1:0], r_bit[OFF_W-1:BIT_W]};
                if (r_func == FN_FREE && cur_bit) begin
                    mem_we = 1'b1;
                    mem_wd = r_rd_data & ~(WORD_BITS'(1) << r_bit[BIT_W-1:0]);
                end else if (r_func == FN_MARK && !cur_bit) begin
                    mem_we = 1'b1;
                    mem_wd = r_rd_data | (WORD_BITS'(1) << r_bit[BIT_W-1:0]);
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Bitmap memory with registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[mem_ra];
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fdb <= 1'b1;
            r_bpg <= BPG_W'(MAX_BPG);
            r_giu <= NG_W'(MAX_GROUPS);
        end else if (i_cfg_we) begin
            priority case (i_cfg_index)
                CFG_FIRST_DATA_BLOCK: r_fdb <= i_cfg_data[0];
                CFG_BLOCKS_PER_GROUP: r_bpg <= i_cfg_data;
                CFG_GROUPS_IN_USE:    r_giu <= i_cfg_data[NG_W-1:0];
                default:              r_fdb <= r_fdb;
            endcase
        end
    end

    // Control and count registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr   <= '0;
            r_pend       <= 1'b0;
            r_issue_done <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int g = 0; g < MAX_GROUPS; g++) begin
                r_cnt[g] <= '0;
            end
        end else begin
            // The output register fills from the finish step and drains on a handshake.
            if (r_state == S_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                end
                S_GRP: begin
                    r_pend       <= 1'b0;
                    r_issue_done <= 1'b0;
                end
                S_SCAN: begin
                    // One word read issued per cycle; its data is checked in the next cycle.
                    if (!r_issue_done) begin
                        r_pend <= 1'b1;
                        if (r_rd_w == last_w) begin
                            r_issue_done <= 1'b1;
                        end
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (scan_hit) begin
                        r_cnt[r_grp[GRP_W-1:0]] <= r_cnt[r_grp[GRP_W-1:0]] + CNT_W'(1);
                    end
                end
                S_LMOD: begin
                    if (r_func == FN_FREE && cur_bit) begin
                        r_cnt[r_grp[GRP_W-1:0]] <= r_cnt[r_grp[GRP_W-1:0]] - CNT_W'(1);
                    end else if (r_func == FN_MARK && !cur_bit) begin
                        r_cnt[r_grp[GRP_W-1:0]] <= r_cnt[r_grp[GRP_W-1:0]] + CNT_W'(1);
                    end
                end
                default: begin
                    r_pend <= r_pend;
                end
            endcase
        end
    end

    // Item datapath.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_func      <= s_axis_tuser;
                r_grp       <= '0;
                r_status    <= ST_RANGE;
                r_res_block <= '0;
            end
            S_GRP: begin
                r_rd_w <= '0;
                if (grp_done) begin
                    r_status <= ST_NO_SPACE;
                end else if (grp_full) begin
                    r_grp <= r_grp + (GRP_W+1)'(1);
                end
            end
            S_SCAN: begin
                if (!r_issue_done) begin
                    r_chk_w <= r_rd_w;
                    r_rd_w  <= r_rd_w + WPG_W'(1);
                end
                if (scan_hit) begin
                    r_bit <= {r_chk_w, free_pos};
                end else if (scan_exhausted) begin
                    r_grp <= r_grp + (GRP_W+1)'(1);
                end
            end
            S_CALC: begin
                r_res_block <= BLK_W'(r_fdb) + grp_base + BLK_W'(r_bit);
                r_status    <= ST_OK;
            end
            S_LOCATE: begin
                if (loc_res.done && loc_res.in_range) begin
                    r_grp <= {1'b0, loc_res.grp};
                    r_bit <= loc_res.offset;
                end
            end
            S_LMOD: begin
                if (r_func == FN_FREE) begin
                    r_status <= cur_bit ? ST_OK : ST_FREE;
                end else begin
                    r_status <= cur_bit ? ST_USED : ST_OK;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    r_out_status <= r_status;
                    r_out_block  <= r_res_block;
                end
            end
            default: begin
                r_func <= r_func;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = TDATA_W'(r_out_block);

endmodule

/* sv/gbba_checker.sv */
module gbba_checker
    import gbba_pkg::*;
#(
    parameter int TDATA_W = 24
)
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic [2:0]         m_axis_tuser
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Status codes stay within the defined set.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_NO_SPACE ||
            m_axis_tuser == ST_RANGE || m_axis_tuser == ST_FREE ||
            m_axis_tuser == ST_USED))
        else $error("undefined status code");

    // Only a successful allocate carries a block number.
    a_block_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0)
        else $error("block number on a failed item");

    // The clearing pass keeps the input closed right after reset.
    a_clear_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !s_axis_tready)
        else $error("item taken during clearing pass");

    // Items are handled one at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while busy");

endmodule

bind grouped_bitmap_block_allocator gbba_checker #(.TDATA_W(TDATA_W)) u_gbba_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* test/tb_top.sv */
`default_nettype none

module tb_top
    import gbba_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TD_W        = 24;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 66;
    localparam int MAX_GAP     = 13;
    localparam int SETTLE_CYC  = 40;
    localparam int TAIL_CYC    = 1200;
    localparam int HOLD_AT     = 100;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 20000;

    // The fourth operation code is not defined and must be rejected.
    localparam logic [1:0] FN_UNDEF = 2'd3;

    typedef struct packed {
        logic [2:0]       status;
        logic [BLK_W-1:0] blk;
    } t_alloc_res;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    // One directed row: an item (op is the operation) or a register write (op is the index).
    typedef struct packed {
        t_row_kind        kind;
        logic [1:0]       op;
        logic [BLK_W-1:0] value;
        logic             typed;
        logic [2:0]       exp_status;
        logic [BLK_W-1:0] exp_block;
    } t_dir_row;

    localparam int DIR_N = 29;
    localparam t_dir_row DIR_TABLE [DIR_N] = '{
        // Reset settings: data area starts at block 1, 8 groups of 8192.
        '{ROW_ITEM, FN_ALLOC, 17'd0,      1'b1, ST_OK,       17'd1},
        '{ROW_ITEM, FN_ALLOC, 17'd0,      1'b1, ST_OK,       17'd2},
        '{ROW_ITEM, FN_FREE,  17'd1,      1'b1, ST_OK,       17'd0},
        '{ROW_ITEM, FN_FREE,  17'd1,      1'b1, ST_FREE,     17'd0},
        '{ROW_ITEM, FN_FREE,  17'd0,      1'b1, ST_RANGE,    17'd0},
        '{ROW_ITEM, FN_MARK,  17'd0,      1'b1, ST_RANGE,    17'd0},
        '{ROW_ITEM, FN_MARK,  17'd65536,  1'b1, ST_OK,       17'd0},
        '{ROW_ITEM, FN_MARK,  17'd65536,  1'b1, ST_USED,     17'd0},
        '{ROW_ITEM, FN_FREE,  17'd65537,  1'b1, ST_RANGE,    17'd0},
        '{ROW_ITEM, FN_UNDEF, 17'd131071, 1'b1, ST_RANGE,    17'd0},
        '{ROW_ITEM, FN_MARK,  17'd131071, 1'b1, ST_RANGE,    17'd0},
        '{ROW_ITEM, FN_MARK,  17'd20,     1'b1, ST_OK,       17'd0},
        '{ROW_ITEM, FN_ALLOC, 17'd131071, 1'b1, ST_OK,       17'd1},
        // Tiny geometry: one group of 8, data area from block 0.
        '{ROW_CFG, CFG_FIRST_DATA_BLOCK, 17'd0,  1'b0, ST_OK, 17'd0},
        '{ROW_CFG, CFG_BLOCKS_PER_GROUP, 17'd13, 1'b0, ST_OK, 17'd0},
        '{ROW_CFG, CFG_GROUPS_IN_USE,    17'd0,  1'b0, ST_OK, 17'd0},
        '{ROW_ITEM, FN_MARK,  17'd7,      1'b0, ST_OK,       17'd0},
        '{ROW_ITEM, FN_MARK,  17'd8,      1'b1, ST_RANGE,    17'd0},
        '{ROW_ITEM, FN_ALLOC, 17'd0,      1'b0, ST_OK,       17'd0},
        '{ROW_ITEM, FN_ALLOC, 17'd0,      1'b0, ST_OK,       17'd0},
        '{ROW_ITEM, FN_ALLOC, 17'd0,      1'b0, ST_OK,       17'd0},
        '{ROW_ITEM, FN_ALLOC, 17'd0,      1'b0, ST_OK,       17'd0},
        // The bit set above the shrunk size still counts, so the group is full.
        '{ROW_ITEM, FN_ALLOC, 17'd0,      1'b1, ST_NO_SPACE, 17'd0},
        '{ROW_ITEM, FN_FREE,  17'd6,      1'b1, ST_FREE,     17'd0},
        '{ROW_CFG, CFG_GROUPS_IN_USE,    17'd15, 1'b0, ST_OK, 17'd0},
        '{ROW_ITEM, FN_ALLOC, 17'd0,      1'b0, ST_OK,       17'd0},
        '{ROW_ITEM, FN_FREE,  17'd131071, 1'b1, ST_RANGE,    17'd0},
        '{ROW_CFG, CFG_BLOCKS_PER_GROUP, 17'd16383, 1'b0, ST_OK, 17'd0},
        '{ROW_ITEM, FN_FREE,  17'd65535,  1'b0, ST_OK,       17'd0}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_index;
    logic [BPG_W-1:0] i_cfg_data;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [TD_W-1:0]  s_axis_tdata;
    logic [1:0]       s_axis_tuser;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [TD_W-1:0]  m_axis_tdata;
    logic [2:0]       m_axis_tuser;

    grouped_bitmap_block_allocator #(
        .TDATA_W(TD_W)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [16:0] block_in
        .s_axis_tuser  (s_axis_tuser),   // [1:0] func
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [16:0] block_out
        .m_axis_tuser  (m_axis_tuser)    // [2:0] status
    );

    // Shadow copy of the allocator: bitmap, counts and register values.
    bit               block_map [MAX_GROUPS*MAX_BPG];
    int unsigned      grp_used [MAX_GROUPS];
    int unsigned      total_used;
    logic             cfg_fdb;
    logic [BPG_W-1:0] cfg_bpg;
    logic [NG_W-1:0]  cfg_groups;

    t_alloc_res       expected_results [$];
    int unsigned      taken_blocks [$];
    int unsigned      errors;
    int unsigned      n_items;
    int unsigned      n_results;
    int unsigned      n_settings;
    int unsigned      status_hits [5];
    bit               no_idle;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_bpg();
        int unsigned v;
        v = int'(cfg_bpg) & ~7;
        if (v < 8) begin
            v = 8;
        end
        if (v > MAX_BPG) begin
            v = MAX_BPG;
        end
        return v;
    endfunction

    function automatic int unsigned eff_groups();
        int unsigned v;
        v = cfg_groups;
        if (v < 1) begin
            v = 1;
        end
        if (v > MAX_GROUPS) begin
            v = MAX_GROUPS;
        end
        return v;
    endfunction

    // Applies one item to the shadow state and returns the result it must produce.
    function automatic t_alloc_res apply_op(logic [1:0] fn, logic [BLK_W-1:0] blk);
        t_alloc_res  r;
        int unsigned bpg;
        int unsigned ng;
        int unsigned rel;
        int unsigned g;
        int unsigned off;
        bit          found;
        bpg = eff_bpg();
        ng = eff_groups();
        found = 1'b0;
        r.status = ST_RANGE;
        r.blk = '0;
        if (fn == FN_ALLOC) begin
            r.status = ST_NO_SPACE;
            for (g = 0; g < ng && !found; g++) begin
                if (grp_used[g] < bpg) begin
                    for (off = 0; off < bpg && !found; off++) begin
                        if (!block_map[g*MAX_BPG + off]) begin
                            block_map[g*MAX_BPG + off] = 1'b1;
                            grp_used[g]++;
                            total_used++;
                            r.status = ST_OK;
                            r.blk = BLK_W'(cfg_fdb + g*bpg + off);
                            found = 1'b1;
                        end
                    end
                end
            end
        end else if ((fn == FN_FREE || fn == FN_MARK) && blk >= cfg_fdb) begin
            rel = blk - cfg_fdb;
            g = rel / bpg;
            off = rel % bpg;
            if (g < ng) begin
                if (fn == FN_FREE) begin
                    if (!block_map[g*MAX_BPG + off]) begin
                        r.status = ST_FREE;
                    end else begin
                        block_map[g*MAX_BPG + off] = 1'b0;
                        grp_used[g]--;
                        total_used--;
                        r.status = ST_OK;
                    end
                end else begin
                    if (block_map[g*MAX_BPG + off]) begin
                        r.status = ST_USED;
                    end else begin
                        block_map[g*MAX_BPG + off] = 1'b1;
                        grp_used[g]++;
                        total_used++;
                        r.status = ST_OK;
                    end
                end
            end
        end
        return r;
    endfunction

    // A random block number inside the data area of the current geometry.
    function automatic logic [BLK_W-1:0] pick_in_range();
        return BLK_W'(cfg_fdb + $urandom_range(0, eff_groups() * eff_bpg() - 1));
    endfunction

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        errors++;
        $display("mismatch at result %0d: %s expected %0d, got %0d",
                 n_results, what, want, got);
    endtask

    // Offers one item after a random gap, waits for it to be taken and queues its result.
    task automatic send_item(input logic [1:0] fn, input logic [BLK_W-1:0] blk,
                             input logic use_typed, input t_alloc_res typed_res);
        int         gap;
        t_alloc_res r;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {{(TD_W-BLK_W){1'b0}}, blk};
        do @(posedge i_clk); while (!s_axis_tready);
        r = apply_op(fn, blk);
        if (r.status == ST_OK && fn == FN_ALLOC) begin
            taken_blocks.push_back(r.blk);
        end else if (r.status == ST_OK && fn == FN_MARK) begin
            taken_blocks.push_back(blk);
        end
        expected_results.push_back(use_typed ? typed_res : r);
        n_items++;
    endtask

    // Stops offering items and waits until every result has come back.
    task automatic settle(input int extra);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [BPG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_FIRST_DATA_BLOCK: cfg_fdb = data[0];
            CFG_BLOCKS_PER_GROUP: cfg_bpg = data;
            CFG_GROUPS_IN_USE:    cfg_groups = data[NG_W-1:0];
            default: ;
        endcase
        taken_blocks.delete();
        n_settings++;
    endtask

    // Result side: random hold-off per item, one long stall, and the comparison.
    initial begin : result_sink
        int         gap;
        t_alloc_res want;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (n_results == HOLD_AT) begin
                gap = HOLD_CYCLES;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            if (m_axis_tuser < 5) begin
                status_hits[m_axis_tuser]++;
            end
            if (expected_results.size() == 0) begin
                note_mismatch("unexpected item, status", 0, m_axis_tuser);
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tuser !== want.status) begin
                    note_mismatch("status", want.status, m_axis_tuser);
                end
                if (m_axis_tdata[BLK_W-1:0] !== want.blk) begin
                    note_mismatch("block_out", want.blk, m_axis_tdata[BLK_W-1:0]);
                end
            end
            n_results++;
        end
    end

    // Ends the run when neither side has moved an item for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        t_alloc_res       typed_res;
        logic [1:0]       fn;
        logic [BLK_W-1:0] blk;
        int unsigned      pick;
        errors = 0;
        n_items = 0;
        n_results = 0;
        n_settings = 0;
        total_used = 0;
        no_idle = 1'b0;
        cfg_fdb = 1'b1;
        cfg_bpg = BPG_W'(MAX_BPG);
        cfg_groups = NG_W'(MAX_GROUPS);
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_FIRST_DATA_BLOCK;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= FN_ALLOC;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows; typed results stand in for the prediction where given.
        for (int k = 0; k < DIR_N; k++) begin
            if (DIR_TABLE[k].kind == ROW_CFG) begin
                settle(SETTLE_CYC);
                write_reg(DIR_TABLE[k].op, BPG_W'(DIR_TABLE[k].value));
            end else begin
                typed_res.status = DIR_TABLE[k].exp_status;
                typed_res.blk = DIR_TABLE[k].exp_block;
                send_item(DIR_TABLE[k].op, DIR_TABLE[k].value, DIR_TABLE[k].typed,
                          typed_res);
            end
        end

        // Random phases, each under its own geometry; the first four are the extremes.
        typed_res = '0;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle(SETTLE_CYC);
            no_idle = (ph % 4 == 3);
            case (ph)
                0: begin
                    write_reg(CFG_FIRST_DATA_BLOCK, 14'd1);
                    write_reg(CFG_BLOCKS_PER_GROUP, 14'd8);
                    write_reg(CFG_GROUPS_IN_USE, 14'd8);
                end
                1: begin
                    write_reg(CFG_FIRST_DATA_BLOCK, 14'd0);
                    write_reg(CFG_BLOCKS_PER_GROUP, 14'd8192);
                    write_reg(CFG_GROUPS_IN_USE, 14'd1);
                end
                2: begin
                    write_reg(CFG_FIRST_DATA_BLOCK, 14'd1);
                    write_reg(CFG_BLOCKS_PER_GROUP, 14'd0);
                    write_reg(CFG_GROUPS_IN_USE, 14'd15);
                end
                3: begin
                    write_reg(CFG_FIRST_DATA_BLOCK, 14'd0);
                    write_reg(CFG_BLOCKS_PER_GROUP, 14'd16);
                    write_reg(CFG_GROUPS_IN_USE, 14'd2);
                end
                default: begin
                    write_reg(CFG_FIRST_DATA_BLOCK, BPG_W'($urandom_range(0, 1)));
                    if ($urandom_range(0, 3) != 0) begin
                        write_reg(CFG_BLOCKS_PER_GROUP, BPG_W'($urandom_range(1, 8) * 8));
                    end else begin
                        write_reg(CFG_BLOCKS_PER_GROUP, BPG_W'($urandom_range(0, 16383)));
                    end
                    write_reg(CFG_GROUPS_IN_USE, BPG_W'($urandom_range(0, 15)));
                end
            endcase

            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                blk = BLK_W'($urandom_range(0, 131071));
                if (pick < 45) begin
                    fn = FN_ALLOC;
                end else if (pick < 65) begin
                    // Mostly frees of blocks known to be in use.
                    fn = FN_FREE;
                    if (taken_blocks.size() != 0 && $urandom_range(0, 2) != 0) begin
                        blk = BLK_W'(taken_blocks[$urandom_range(0, taken_blocks.size() - 1)]);
                    end else begin
                        blk = pick_in_range();
                    end
                end else if (pick < 82) begin
                    fn = FN_MARK;
                    blk = pick_in_range();
                end else if (pick < 90) begin
                    // Edges of the data area: just below, last valid, first beyond.
                    fn = ($urandom_range(0, 1) != 0) ? FN_FREE : FN_MARK;
                    case ($urandom_range(0, 2))
                        0: blk = BLK_W'(cfg_fdb) - 1'b1;
                        1: blk = BLK_W'(cfg_fdb + eff_groups() * eff_bpg() - 1);
                        default: blk = BLK_W'(cfg_fdb + eff_groups() * eff_bpg());
                    endcase
                end else begin
                    fn = 2'($urandom_range(0, 3));
                end
                send_item(fn, blk, 1'b0, typed_res);
            end
        end

        settle(TAIL_CYC);
        $display("Ran %0d items over %0d register writes; %0d results checked.",
                 n_items, n_settings, n_results);
        $display("Blocks in use at end %0d; statuses ok %0d, no space %0d, range %0d, %s",
                 total_used, status_hits[0], status_hits[1], status_hits[2],
                 $sformatf("already free %0d, already used %0d.",
                           status_hits[3], status_hits[4]));
        if (errors == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
